// ===== sv/ane_pkg.sv =====
// Package for the ASCII number extractor: fixed field widths, character
// codes and the result item type. No dependencies.
`timescale 1ns / 1ps

package ane_pkg;

   localparam int INT_W  = 31;   // int_magnitude field width
   localparam int FRAC_W = 30;   // frac_value field width
   localparam int CNT_W  = 4;    // frac_count field width

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;

   typedef struct packed {
      logic              found;
      logic              negative;
      logic [INT_W-1:0]  int_magnitude;
      logic [FRAC_W-1:0] frac_value;
      logic [CNT_W-1:0]  frac_count;
      logic              saturated;
      logic              end_of_string;
   } result_type;

endpackage

// ===== sv/ascii_number_extractor_core.sv =====
// ASCII number extractor top level: input register, scanner and result
// register with valid/ready on both sides. Uses ane_pkg and ane_scan.
`timescale 1ns / 1ps

// Usage
//   req_*  : one character per item (char_code, last_char), valid/ready.
//   rsp_*  : one number per item, at most one per character, valid/ready.
//   csr_*  : decimal_mode, written on csr_wr_en; only while nothing is in
//            flight. Reset value 1 (fractions after a dot are taken).
// A character is taken into the input register and scanned from there, its
// result (if any) landing in the output register, which drives rsp_valid; a
// stalled output register holds the character in the input register unscanned.
// Throughput is one character per cycle while the receiver does not stall;
// the limit is the multiply-by-ten-and-add on the integer or fraction
// accumulator between the input and output registers.
// A non-digit ending a number gives one item; the last character of a string
// always gives one (found = 0 if nothing was pending) and clears the scanner.
// When the receiver stalls, the result waits in the output register and the
// input register still holds one further character; req_ready then drops.
// Reset (synchronous) empties both registers and clears the scanner.

module ascii_number_extractor_core #(
   parameter int MAG_BITS        = 31,
   parameter int FRAC_DIGITS_MAX = 9
) (
   input  logic                         clock,
   input  logic                         reset,
   // character items
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [7:0]                   req_char_code,
   input  logic                         req_last_char,
   // result items
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_found,
   output logic                         rsp_negative,
   output logic [ane_pkg::INT_W-1:0]    rsp_int_magnitude,
   output logic [ane_pkg::FRAC_W-1:0]   rsp_frac_value,
   output logic [ane_pkg::CNT_W-1:0]    rsp_frac_count,
   output logic                         rsp_saturated,
   output logic                         rsp_end_of_string,
   // configuration
   input  logic                         csr_wr_en,
   input  logic                         csr_wr_data
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_char_ff;
   logic       in_last_ff;

   // output register
   logic                out_valid_ff, out_valid_in;
   ane_pkg::result_type out_ff;

   logic mode_ff, mode_in;

   logic                advance;
   logic                scan_valid;
   ane_pkg::result_type scan_result;

   // the held character moves on when the output register is free or
   // emptying this cycle
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign in_valid_in  = req_ready ? req_valid : in_valid_ff;
   assign out_valid_in = (advance && scan_valid) ? 1'b1 :
                         (rsp_ready ? 1'b0 : out_valid_ff);
   assign mode_in      = csr_wr_en ? csr_wr_data : mode_ff;

   ane_scan #(
      .MAG_BITS        (MAG_BITS),
      .FRAC_DIGITS_MAX (FRAC_DIGITS_MAX)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .step_en      (advance),
      .char_code    (in_char_ff),
      .last_char    (in_last_ff),
      .decimal_mode (mode_ff),
      .result_valid (scan_valid),
      .result       (scan_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mode_ff      <= 1'b1;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         mode_ff      <= mode_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_char_ff <= req_char_code;
         in_last_ff <= req_last_char;
      end
      if (advance && scan_valid) begin
         out_ff <= scan_result;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_found         = out_ff.found;
   assign rsp_negative      = out_ff.negative;
   assign rsp_int_magnitude = out_ff.int_magnitude;
   assign rsp_frac_value    = out_ff.frac_value;
   assign rsp_frac_count    = out_ff.frac_count;
   assign rsp_saturated     = out_ff.saturated;
   assign rsp_end_of_string = out_ff.end_of_string;

endmodule

// ===== sv/ane_scan.sv =====
// Character scanner of the ASCII number extractor: holds the number being
// built and works one character per step. Uses ane_pkg.
`timescale 1ns / 1ps

module ane_scan #(
   parameter int MAG_BITS        = 31,
   parameter int FRAC_DIGITS_MAX = 9
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  logic [7:0]             char_code,
   input  logic                   last_char,
   input  logic                   decimal_mode,
   output logic                   result_valid,
   output ane_pkg::result_type    result
);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_INT  = 2'd1;
   localparam logic [1:0] PH_DOT  = 2'd2;
   localparam logic [1:0] PH_FRAC = 2'd3;

   localparam int IntW  = ane_pkg::INT_W;
   localparam int FracW = ane_pkg::FRAC_W;
   localparam int CntW  = ane_pkg::CNT_W;

   localparam logic [MAG_BITS-1:0] MagLimit = '1;
   localparam logic [CntW-1:0]     FracMax  = CntW'(FRAC_DIGITS_MAX);

   logic [1:0]          phase_ff, phase_in;
   logic                minus_ff, minus_in;
   logic                sign_ff, sign_in;
   logic [MAG_BITS-1:0] int_ff, int_in;
   logic [FracW-1:0]    frac_ff, frac_in;
   logic [CntW-1:0]     cnt_ff, cnt_in;
   logic                ovf_ff, ovf_in;

   logic                is_digit;
   logic [3:0]          digit;
   logic                ended;
   logic [MAG_BITS+3:0] int_prod;
   logic [FracW+3:0]    frac_prod;

   // next state after one character, state updated only on step_en
   logic [1:0]          phase_nx;
   logic                sign_nx;
   logic [MAG_BITS-1:0] int_nx;
   logic [FracW-1:0]    frac_nx;
   logic [CntW-1:0]     cnt_nx;
   logic                ovf_nx;

   assign is_digit  = (char_code >= ane_pkg::CHAR_ZERO) && (char_code <= ane_pkg::CHAR_NINE);
   assign digit     = is_digit ? 4'(char_code - ane_pkg::CHAR_ZERO) : 4'd0;
   // x*10 + d as shifts and adds
   assign int_prod  = ({4'd0, int_ff} << 3) + ({4'd0, int_ff} << 1)
                    + (MAG_BITS+4)'(digit);
   assign frac_prod = ({4'd0, frac_ff} << 3) + ({4'd0, frac_ff} << 1)
                    + (FracW+4)'(digit);

   always_comb begin
      phase_nx = phase_ff;
      sign_nx  = sign_ff;
      int_nx   = int_ff;
      frac_nx  = frac_ff;
      cnt_nx   = cnt_ff;
      ovf_nx   = ovf_ff;
      ended    = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            if (is_digit) begin
               sign_nx  = minus_ff;
               int_nx   = MAG_BITS'(digit);
               frac_nx  = '0;
               cnt_nx   = '0;
               ovf_nx   = 1'b0;
               phase_nx = PH_INT;
            end
         end
         PH_INT: begin
            if (is_digit) begin
               if (int_prod > {4'd0, MagLimit}) begin
                  int_nx = MagLimit;
                  ovf_nx = 1'b1;
               end else begin
                  int_nx = int_prod[MAG_BITS-1:0];
               end
            end else if (char_code == ane_pkg::CHAR_DOT && decimal_mode) begin
               phase_nx = PH_DOT;
            end else begin
               ended = 1'b1;
            end
         end
         PH_DOT, PH_FRAC: begin
            if (is_digit) begin
               phase_nx = PH_FRAC;
               if (cnt_ff < FracMax) begin
                  frac_nx = frac_prod[FracW-1:0];
                  cnt_nx  = cnt_ff + 1'b1;
               end
            end else begin
               ended = 1'b1;
            end
         end
         default: begin
            phase_nx = PH_IDLE;
         end
      endcase
   end

   // result of this step
   logic found;
   assign found        = ended || (last_char && phase_nx != PH_IDLE);
   assign result_valid = ended || last_char;

   always_comb begin
      result.found         = found;
      result.negative      = found & sign_nx;
      result.int_magnitude = found ? IntW'({{IntW{1'b0}}, int_nx}) : '0;
      result.frac_value    = found ? frac_nx : '0;
      result.frac_count    = found ? cnt_nx : '0;
      result.saturated     = found & ovf_nx;
      result.end_of_string = last_char;
   end

   always_comb begin
      phase_in = phase_ff;
      minus_in = minus_ff;
      sign_in  = sign_ff;
      int_in   = int_ff;
      frac_in  = frac_ff;
      cnt_in   = cnt_ff;
      ovf_in   = ovf_ff;
      if (step_en) begin
         if (last_char) begin
            phase_in = PH_IDLE;
            minus_in = 1'b0;
            sign_in  = 1'b0;
            int_in   = '0;
            frac_in  = '0;
            cnt_in   = '0;
            ovf_in   = 1'b0;
         end else begin
            phase_in = ended ? PH_IDLE : phase_nx;
            minus_in = (char_code == ane_pkg::CHAR_MINUS);
            sign_in  = sign_nx;
            int_in   = int_nx;
            frac_in  = frac_nx;
            cnt_in   = cnt_nx;
            ovf_in   = ovf_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         minus_ff <= 1'b0;
         sign_ff  <= 1'b0;
         int_ff   <= '0;
         frac_ff  <= '0;
         cnt_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         minus_ff <= minus_in;
         sign_ff  <= sign_in;
         int_ff   <= int_in;
         frac_ff  <= frac_in;
         cnt_ff   <= cnt_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

// ===== sim/tb_top.sv =====
// Self-checking bench for ascii_number_extractor_core: directed character
// table then random text, each result checked against a local number scanner.
// Depends on ane_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_top;

   localparam int MAG_BITS        = 31;
   localparam int FRAC_DIGITS_MAX = 9;
   localparam int PHASE_ITEMS     = 85;    // random characters per phase, at least
   localparam int NUM_PHASES      = 8;

   localparam int INT_W  = ane_pkg::INT_W;
   localparam int FRAC_W = ane_pkg::FRAC_W;
   localparam int CNT_W  = ane_pkg::CNT_W;

   localparam logic [7:0] CHAR_ZERO  = ane_pkg::CHAR_ZERO;
   localparam logic [7:0] CHAR_NINE  = ane_pkg::CHAR_NINE;
   localparam logic [7:0] CHAR_MINUS = ane_pkg::CHAR_MINUS;
   localparam logic [7:0] CHAR_DOT   = ane_pkg::CHAR_DOT;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;

   localparam logic [63:0] MAG_LIMIT = (64'd1 << MAG_BITS) - 64'd1;

   typedef enum logic [1:0] {SCAN_IDLE, SCAN_INT, SCAN_DOT, SCAN_FRAC} scan_phase_type;

   // one row of the directed table; want is only used when typed is set
   typedef struct packed {
      logic [7:0]          ch;
      logic                last;
      logic                typed;
      ane_pkg::result_type want;
   } stim_row_type;

   localparam ane_pkg::result_type NO_WANT     = '0;
   localparam ane_pkg::result_type RES_NOTHING = '{found: 1'b0, negative: 1'b0,
                                                   int_magnitude: '0,
                                                   frac_value: '0, frac_count: '0,
                                                   saturated: 1'b0,
                                                   end_of_string: 1'b1};
   // -9999999999.9999999999 then a last character: integer saturated, fraction at its digit limit
   localparam ane_pkg::result_type RES_BIG = '{found: 1'b1, negative: 1'b1,
                                               int_magnitude: 31'h7FFF_FFFF,
                                               frac_value: 30'd999_999_999,
                                               frac_count: 4'd9,
                                               saturated: 1'b1, end_of_string: 1'b1};

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [7:0]          req_char_code = '0;
   logic                req_last_char = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_found;
   logic                rsp_negative;
   logic [INT_W-1:0]    rsp_int_magnitude;
   logic [FRAC_W-1:0]   rsp_frac_value;
   logic [CNT_W-1:0]    rsp_frac_count;
   logic                rsp_saturated;
   logic                rsp_end_of_string;
   logic                csr_wr_en = 1'b0;
   logic                csr_wr_data = 1'b0;

   // scanner mirror: the number being built, plus the decimal_mode copy
   scan_phase_type      scan_at = SCAN_IDLE;
   bit                  minus_last = 1'b0;
   bit                  num_neg = 1'b0;
   logic [63:0]         int_acc = '0;
   logic [FRAC_W-1:0]   frac_acc = '0;
   logic [CNT_W-1:0]    frac_kept = '0;
   bit                  int_sat = 1'b0;
   bit                  decimal_on = 1'b1;

   ane_pkg::result_type expected_numbers [$];
   int                  mismatch_count = 0;
   int                  sender_idle_pct = 0;
   int                  receiver_stall_pct = 0;

   stim_row_type directed_rows [30] = '{
      '{8'h00, 1'b1, 1'b1, RES_NOTHING},          // empty string, nothing found
      '{CHAR_MINUS, 1'b0, 1'b0, NO_WANT},
      '{CHAR_NINE, 1'b0, 1'b0, NO_WANT}, '{CHAR_NINE, 1'b0, 1'b0, NO_WANT},
      '{CHAR_NINE, 1'b0, 1'b0, NO_WANT}, '{CHAR_NINE, 1'b0, 1'b0, NO_WANT},
      '{CHAR_NINE, 1'b0, 1'b0, NO_WANT}, '{CHAR_NINE, 1'b0, 1'b0, NO_WANT},
      '{CHAR_NINE, 1'b0, 1'b0, NO_WANT}, '{CHAR_NINE, 1'b0, 1'b0, NO_WANT},
      '{CHAR_NINE, 1'b0, 1'b0, NO_WANT}, '{CHAR_NINE, 1'b0, 1'b0, NO_WANT},
      '{CHAR_DOT, 1'b0, 1'b0, NO_WANT},
      '{CHAR_NINE, 1'b0, 1'b0, NO_WANT}, '{CHAR_NINE, 1'b0, 1'b0, NO_WANT},
      '{CHAR_NINE, 1'b0, 1'b0, NO_WANT}, '{CHAR_NINE, 1'b0, 1'b0, NO_WANT},
      '{CHAR_NINE, 1'b0, 1'b0, NO_WANT}, '{CHAR_NINE, 1'b0, 1'b0, NO_WANT},
      '{CHAR_NINE, 1'b0, 1'b0, NO_WANT}, '{CHAR_NINE, 1'b0, 1'b0, NO_WANT},
      '{CHAR_NINE, 1'b0, 1'b0, NO_WANT}, '{CHAR_NINE, 1'b0, 1'b0, NO_WANT}, // last one dropped
      '{8'hFF, 1'b1, 1'b1, RES_BIG},
      // +5.-3. : dot without a digit, then a dot as the last character
      '{CHAR_PLUS, 1'b0, 1'b0, NO_WANT},
      '{CHAR_ZERO + 8'd5, 1'b0, 1'b0, NO_WANT},
      '{CHAR_DOT, 1'b0, 1'b0, NO_WANT},
      '{CHAR_MINUS, 1'b0, 1'b0, NO_WANT},
      '{CHAR_ZERO + 8'd3, 1'b0, 1'b0, NO_WANT},
      '{CHAR_DOT, 1'b1, 1'b0, NO_WANT}
   };

   ascii_number_extractor_core #(
      .MAG_BITS        (MAG_BITS),
      .FRAC_DIGITS_MAX (FRAC_DIGITS_MAX)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_char_code     (req_char_code),
      .req_last_char     (req_last_char),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_found         (rsp_found),
      .rsp_negative      (rsp_negative),
      .rsp_int_magnitude (rsp_int_magnitude),
      .rsp_frac_value    (rsp_frac_value),
      .rsp_frac_count    (rsp_frac_count),
      .rsp_saturated     (rsp_saturated),
      .rsp_end_of_string (rsp_end_of_string),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Number scanner. Steps one accepted character; returns 1 when the
   // character yields a result item, which is left in res.
   // ------------------------------------------------------------------
   function automatic bit scan_char(input logic [7:0] ch, input logic last,
                                    output ane_pkg::result_type res);
      bit          is_digit;
      bit          ended;
      bit          found;
      logic [63:0] d;
      is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
      d        = is_digit ? 64'(ch - CHAR_ZERO) : 64'd0;
      ended    = 1'b0;
      res      = '0;

      case (scan_at)
         SCAN_IDLE: begin
            if (is_digit) begin
               num_neg   = minus_last;
               int_acc   = d;
               frac_acc  = '0;
               frac_kept = '0;
               int_sat   = 1'b0;
               scan_at   = SCAN_INT;
            end
         end
         SCAN_INT: begin
            if (is_digit) begin
               // saturate rather than wrap; the flag sticks for this number
               if (int_acc > (MAG_LIMIT - d) / 64'd10) begin
                  int_acc = MAG_LIMIT;
                  int_sat = 1'b1;
               end else begin
                  int_acc = int_acc * 64'd10 + d;
               end
            end else if (ch == CHAR_DOT && decimal_on) begin
               scan_at = SCAN_DOT;   // mode only matters here
            end else begin
               ended = 1'b1;
            end
         end
         default: begin
            // dot seen or inside the fraction: digits past the limit are dropped
            if (is_digit) begin
               scan_at = SCAN_FRAC;
               if (frac_kept < FRAC_DIGITS_MAX) begin
                  frac_acc  = FRAC_W'(frac_acc * 64'd10 + d);
                  frac_kept = frac_kept + 1'b1;
               end
            end else begin
               ended = 1'b1;
            end
         end
      endcase
      minus_last = (ch == CHAR_MINUS);

      found = ended || (last && scan_at != SCAN_IDLE);
      if (found) begin
         res.found         = 1'b1;
         res.negative      = num_neg;
         res.int_magnitude = int_acc[INT_W-1:0];
         res.frac_value    = frac_acc;
         res.frac_count    = frac_kept;
         res.saturated     = int_sat;
      end
      res.end_of_string = last;

      if (last) begin
         // end of string: everything back to reset, mode kept
         scan_at    = SCAN_IDLE;
         minus_last = 1'b0;
         num_neg    = 1'b0;
         int_acc    = '0;
         frac_acc   = '0;
         frac_kept  = '0;
         int_sat    = 1'b0;
      end else if (ended) begin
         scan_at = SCAN_IDLE;
      end
      return found || last;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   // ------------------------------------------------------------------
   // Character sender. Optionally idles first, then holds the item until
   // it is taken. On acceptance the expected number (if any) is queued;
   // a typed row replaces the scanner's answer by the one in the table.
   // ------------------------------------------------------------------
   task automatic send_char(input logic [7:0] ch, input logic last,
                            input bit use_typed, input ane_pkg::result_type typed);
      ane_pkg::result_type res;
      bit                  produced;
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_valid     <= 1'b1;
      req_char_code <= ch;
      req_last_char <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      produced = scan_char(ch, last, res);
      if (use_typed)
         expected_numbers.push_back(typed);
      else if (produced)
         expected_numbers.push_back(res);
   endtask

   // Stop sending and wait until every expected item is back, plus a few
   // cycles for a character still in the pipe that yields nothing.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_numbers.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_decimal_mode(input bit mode);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      decimal_on = mode;
      csr_wr_en <= 1'b0;
   endtask

   // Optional sign, integer digits, optional dot and fraction. Mostly short,
   // now and then long enough to saturate or to overrun the fraction limit.
   task automatic make_number(ref logic [7:0] text [$]);
      int sign_pick;
      int n_int;
      int n_frac;
      sign_pick = $urandom_range(99);
      if (sign_pick < 30)
         text.push_back(CHAR_MINUS);
      else if (sign_pick < 38)
         text.push_back(CHAR_PLUS);
      n_int = ($urandom_range(99) < 6) ? $urandom_range(10, 12) : $urandom_range(1, 4);
      repeat (n_int) text.push_back(CHAR_ZERO + 8'($urandom_range(9)));
      if ($urandom_range(99) < 55) begin
         text.push_back(CHAR_DOT);
         n_frac = ($urandom_range(99) < 10) ? $urandom_range(9, 11) : $urandom_range(0, 3);
         repeat (n_frac) text.push_back(CHAR_ZERO + 8'($urandom_range(9)));
      end
   endtask

   task automatic make_separator(ref logic [7:0] text [$]);
      logic [7:0] seps [6];
      seps = '{CHAR_SPACE, CHAR_COMMA, CHAR_SEMI, CHAR_MINUS, CHAR_PLUS, CHAR_DOT};
      repeat ($urandom_range(1, 2)) begin
         if ($urandom_range(99) < 75)
            text.push_back(seps[$urandom_range(5)]);
         else
            text.push_back(8'($urandom_range(255)));
      end
   endtask

   // ------------------------------------------------------------------
   // Result checker: every accepted result item against the oldest
   // expectation, field by field.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : check_results
      ane_pkg::result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_numbers.size() == 0) begin
            report_mismatch("unexpected item", 64'(rsp_int_magnitude), 64'd0);
         end else begin
            want = expected_numbers.pop_front();
            if (rsp_found !== want.found)
               report_mismatch("found", 64'(rsp_found), 64'(want.found));
            if (rsp_negative !== want.negative)
               report_mismatch("negative", 64'(rsp_negative), 64'(want.negative));
            if (rsp_int_magnitude !== want.int_magnitude)
               report_mismatch("int_magnitude", 64'(rsp_int_magnitude),
                               64'(want.int_magnitude));
            if (rsp_frac_value !== want.frac_value)
               report_mismatch("frac_value", 64'(rsp_frac_value), 64'(want.frac_value));
            if (rsp_frac_count !== want.frac_count)
               report_mismatch("frac_count", 64'(rsp_frac_count), 64'(want.frac_count));
            if (rsp_saturated !== want.saturated)
               report_mismatch("saturated", 64'(rsp_saturated), 64'(want.saturated));
            if (rsp_end_of_string !== want.end_of_string)
               report_mismatch("end_of_string", 64'(rsp_end_of_string),
                               64'(want.end_of_string));
         end
      end
   end

   // receiver back-pressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // ------------------------------------------------------------------
   // Stimulus: directed table, then phases of random text. Each phase
   // picks an idling pattern and a decimal_mode setting; a phase may end
   // part way through a number so that the mode changes under it.
   // ------------------------------------------------------------------
   initial begin : stimulus
      logic [7:0] text [$];
      int         sent;
      bit         mode;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      write_decimal_mode(1'b1);

      foreach (directed_rows[i])
         send_char(directed_rows[i].ch, directed_rows[i].last,
                   directed_rows[i].typed, directed_rows[i].want);
      wait_drained();

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 74; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 74; end
            default: begin sender_idle_pct = 14; receiver_stall_pct = 14; end
         endcase
         mode = ph[0] ^ ph[1] ^ ph[2];
         write_decimal_mode(mode);

         sent = 0;
         while (sent < PHASE_ITEMS) begin
            text.delete();
            repeat ($urandom_range(1, 4)) begin
               if ($urandom_range(99) < 70) make_separator(text);
               if ($urandom_range(99) < 85) begin
                  make_number(text);
               end else begin
                  // plain noise
                  repeat ($urandom_range(1, 4)) text.push_back(8'($urandom_range(255)));
               end
            end
            if ($urandom_range(99) < 30) make_separator(text);
            foreach (text[i])
               send_char(text[i], i == text.size() - 1, 1'b0, NO_WANT);
            sent += text.size();
         end

         // half the time leave a number open across the mode write
         if ($urandom_range(1)) begin
            text.delete();
            make_number(text);
            foreach (text[i]) send_char(text[i], 1'b0, 1'b0, NO_WANT);
         end
         wait_drained();
      end

      // close any open string so the last number comes out
      send_char(CHAR_SPACE, 1'b1, 1'b0, NO_WANT);
      wait_drained();
      repeat (10) @(posedge clock);

      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // hard stop well beyond the slowest legal run
   initial begin : watchdog
      #5_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

// ===== files.f =====
sv/ane_pkg.sv
sv/ane_scan.sv
sv/ascii_number_extractor_core.sv
sim/tb_top.sv
